>>> rtl/mbr_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus RTU master.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none
package mbr_pkg;

   // Command codes carried on the request tuser
   localparam logic [2:0] CMD_START_WRITE = 3'd0;
   localparam logic [2:0] CMD_START_READ  = 3'd1;
   localparam logic [2:0] CMD_RX_BYTE     = 3'd2;
   localparam logic [2:0] CMD_FRAME_END   = 3'd3;
   localparam logic [2:0] CMD_TICK        = 3'd4;

   // Completion status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
   localparam logic [1:0] STATUS_LEN_CRC  = 2'd2;
   localparam logic [1:0] STATUS_MISMATCH = 2'd3;

   // Result kinds
   localparam logic KIND_TX_BYTE   = 1'b0;
   localparam logic KIND_COMPLETE  = 1'b1;

   localparam int unsigned RX_MAX_BYTES_DEF = 64;
   localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;
   localparam logic [15:0] TICK_MAX         = 16'hFFFF;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] FUNC_WRITE  = 8'h10;
   localparam logic [7:0] FUNC_READ   = 8'h03;
   localparam logic [7:0] REG_COUNT   = 8'h04;
   localparam logic [7:0] BYTE_COUNT  = 8'h08;

   // Request frame lengths, CRC included
   localparam logic [4:0] TX_LEN_WRITE = 5'd17;
   localparam logic [4:0] TX_LEN_READ  = 5'd8;

   // Expected response lengths and receive buffer depth
   localparam int unsigned RSP_LEN_WRITE = 8;
   localparam int unsigned RSP_LEN_READ  = 13;
   localparam int unsigned BUF_DEPTH     = 13;

   localparam int unsigned LEN_W = 7;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } tx_out_type;

   typedef struct packed {
      logic             valid;
      logic [1:0]       status;
      logic [63:0]      value;
      logic [LEN_W-1:0] length;
   } cpl_type;

   // One byte of CRC-16/MODBUS, reflected polynomial
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

>>> rtl/mbr_tx.sv
// Request frame emitter: one byte per cycle while out_ready is high, with a running CRC.
// Depends on mbr_pkg.
`default_nettype none
module mbr_tx import mbr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        start_write,
   input  wire logic [7:0]  dev_id,
   input  wire logic [15:0] first_reg,
   input  wire logic [63:0] write_value,
   input  wire logic        out_ready,
   output logic             busy,
   output tx_out_type       tx_out
);

   logic        busy_ff, busy_in;
   logic [4:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic        write_ff, write_in;
   logic [7:0]  slave_ff, slave_in;
   logic [15:0] reg_ff, reg_in;
   logic [63:0] value_ff, value_in;

   logic [4:0]  len;
   logic        emit;
   logic        is_last;
   logic        is_crc;
   logic [7:0]  byte_out;

   assign len     = write_ff ? TX_LEN_WRITE : TX_LEN_READ;
   assign emit    = busy_ff && out_ready;
   assign is_last = (idx_ff == len - 5'd1);
   assign is_crc  = (idx_ff == len - 5'd2) || is_last;

   always_comb begin
      priority if (idx_ff == len - 5'd2) begin
         byte_out = crc_ff[7:0];
      end else if (is_last) begin
         byte_out = crc_ff[15:8];
      end else begin
         unique case (idx_ff)
            5'd0:    byte_out = slave_ff;
            5'd1:    byte_out = write_ff ? FUNC_WRITE : FUNC_READ;
            5'd2:    byte_out = reg_ff[15:8];
            5'd3:    byte_out = reg_ff[7:0];
            5'd4:    byte_out = 8'h00;
            5'd5:    byte_out = REG_COUNT;
            5'd6:    byte_out = BYTE_COUNT;
            5'd7:    byte_out = value_ff[15:8];
            5'd8:    byte_out = value_ff[7:0];
            5'd9:    byte_out = value_ff[31:24];
            5'd10:   byte_out = value_ff[23:16];
            5'd11:   byte_out = value_ff[47:40];
            5'd12:   byte_out = value_ff[39:32];
            5'd13:   byte_out = value_ff[63:56];
            5'd14:   byte_out = value_ff[55:48];
            default: byte_out = 8'h00;
         endcase
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      crc_in   = crc_ff;
      write_in = write_ff;
      slave_in = slave_ff;
      reg_in   = reg_ff;
      value_in = value_ff;
      if (start) begin
         busy_in  = 1'b1;
         idx_in   = 5'd0;
         crc_in   = CRC_INIT;
         write_in = start_write;
         slave_in = dev_id;
         reg_in   = first_reg;
         value_in = write_value;
      end else if (emit) begin
         idx_in = idx_ff + 5'd1;
         if (!is_crc) begin
            crc_in = crc_feed(crc_ff, byte_out);
         end
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      idx_ff   <= idx_in;
      crc_ff   <= crc_in;
      write_ff <= write_in;
      slave_ff <= slave_in;
      reg_ff   <= reg_in;
      value_ff <= value_in;
   end

   assign busy         = busy_ff;
   assign tx_out.valid = emit;
   assign tx_out.data  = byte_out;
   assign tx_out.last  = is_last;

endmodule
`default_nettype wire

>>> rtl/mbr_rx.sv
// Response tracker: phase, receive buffer, running CRC, timeout and frame judging.
// Depends on mbr_pkg.
`default_nettype none
module mbr_rx import mbr_pkg::*; #(
   parameter int unsigned RX_MAX_BYTES = RX_MAX_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [2:0]  cmd,
   input  wire logic [7:0]  dev_id,
   input  wire logic [15:0] first_reg,
   input  wire logic [7:0]  rx_byte,
   input  wire logic [15:0] timeout_ticks,
   output cpl_type          cpl
);

   localparam int unsigned CNT_W = $clog2(RX_MAX_BYTES + 1);

   typedef enum logic [1:0] {
      PH_IDLE       = 2'd0,
      PH_WAIT_WRITE = 2'd1,
      PH_WAIT_READ  = 2'd2
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [7:0]       slave_ff, slave_in;
   logic [15:0]      reg_ff, reg_in;
   logic [15:0]      wait_ff, wait_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       buf_ff [BUF_DEPTH];

   logic        waiting, is_write, is_start, store_byte;
   logic [15:0] tick_next;
   logic        timed_out, len_bad, field_bad;
   logic [63:0] read_value;

   assign waiting    = (phase_ff != PH_IDLE);
   assign is_write   = (phase_ff == PH_WAIT_WRITE);
   assign is_start   = (cmd == CMD_START_WRITE) || (cmd == CMD_START_READ);
   assign store_byte = accept && waiting && (cmd == CMD_RX_BYTE) &&
                       (count_ff < CNT_W'(RX_MAX_BYTES));
   assign tick_next  = (wait_ff != TICK_MAX) ? wait_ff + 16'd1 : wait_ff;
   assign timed_out  = (tick_next >= timeout_ticks);

   // Judge the response as it stands
   assign len_bad = (count_ff != (is_write ? CNT_W'(RSP_LEN_WRITE) : CNT_W'(RSP_LEN_READ))) ||
                    (crc_ff != 16'h0000);

   always_comb begin
      if (is_write) begin
         field_bad = (buf_ff[0] != slave_ff) || (buf_ff[1] != FUNC_WRITE) ||
                     ({buf_ff[2], buf_ff[3]} != reg_ff) ||
                     ({buf_ff[4], buf_ff[5]} != {8'h00, REG_COUNT});
      end else begin
         field_bad = (buf_ff[0] != slave_ff) || (buf_ff[1] != FUNC_READ) ||
                     (buf_ff[2] != BYTE_COUNT);
      end
   end

   assign read_value = {buf_ff[9], buf_ff[10], buf_ff[7], buf_ff[8],
                        buf_ff[5], buf_ff[6], buf_ff[3], buf_ff[4]};

   always_comb begin
      cpl.valid  = 1'b0;
      cpl.status = STATUS_OK;
      cpl.value  = 64'd0;
      cpl.length = LEN_W'(count_ff);
      if (accept && waiting) begin
         if (cmd == CMD_FRAME_END) begin
            cpl.valid = 1'b1;
            priority if (len_bad) begin
               cpl.status = STATUS_LEN_CRC;
            end else if (field_bad) begin
               cpl.status = STATUS_MISMATCH;
            end else begin
               cpl.status = STATUS_OK;
               cpl.value  = is_write ? 64'd0 : read_value;
            end
         end else if (cmd == CMD_TICK && timed_out) begin
            cpl.valid  = 1'b1;
            cpl.status = STATUS_TIMEOUT;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      slave_in = slave_ff;
      reg_in   = reg_ff;
      wait_in  = wait_ff;
      count_in = count_ff;
      crc_in   = crc_ff;
      if (accept) begin
         if (is_start) begin
            phase_in = (cmd == CMD_START_WRITE) ? PH_WAIT_WRITE : PH_WAIT_READ;
            slave_in = dev_id;
            reg_in   = first_reg;
            wait_in  = 16'd0;
            count_in = '0;
            crc_in   = CRC_INIT;
         end else if (waiting) begin
            if (store_byte) begin
               crc_in   = crc_feed(crc_ff, rx_byte);
               count_in = count_ff + CNT_W'(1);
            end
            if (cmd == CMD_FRAME_END) begin
               phase_in = PH_IDLE;
            end
            if (cmd == CMD_TICK) begin
               wait_in = tick_next;
               if (timed_out) begin
                  phase_in = PH_IDLE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         slave_ff <= 8'h00;
         reg_ff   <= 16'h0000;
         wait_ff  <= 16'h0000;
         count_ff <= '0;
         crc_ff   <= CRC_INIT;
      end else begin
         phase_ff <= phase_in;
         slave_ff <= slave_in;
         reg_ff   <= reg_in;
         wait_ff  <= wait_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
      end
   end

   // Buffer only the first bytes of the response
   always_ff @(posedge clock) begin
      for (int e = 0; e < BUF_DEPTH; e++) begin
         if (store_byte && (count_ff == CNT_W'(e))) begin
            buf_ff[e] <= rx_byte;
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/modbus_rtu_master_u64_transaction.sv
// Modbus RTU master for one 64-bit value in four holding registers.
// Latency: a non-start item gives its completion (if any) on rsp the cycle after acceptance.
// A start item is accepted in a single handshake; its 17 (write) or 8 (read) bytes then leave the
// byte emitter one per cycle while the output register is free; req_tready stays low until the
// last byte is loaded. Other items are taken every cycle while the output register drains.
// Synchronous reset returns to idle with timeout_ticks 1000; the receive buffer is not cleared.
`default_nettype none
module modbus_rtu_master_u64_transaction import mbr_pkg::*; #(
   parameter int unsigned RX_MAX_BYTES = RX_MAX_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,  // dev_id, first_reg, write_value, rx_byte
   input  wire logic [2:0]  req_tuser,  // cmd
   // Result items
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,  // tx_byte, status, read_value, response_length, pad
   output logic             rsp_tuser,  // kind
   output logic             rsp_tlast,  // last
   // Timeout register
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   logic [15:0] timeout_ff, timeout_in;

   logic             out_ready;
   logic             accept;
   logic             start;
   logic             tx_busy;
   tx_out_type       tx_out;
   cpl_type          cpl;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             kind_ff, kind_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic [1:0]       status_ff, status_in;
   logic [63:0]      value_ff, value_in;
   logic [LEN_W-1:0] length_ff, length_in;

   // The output register frees up when empty or being taken
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign req_tready = out_ready && !tx_busy;
   assign accept     = req_tvalid && req_tready;
   assign start      = accept &&
                       ((req_tuser == CMD_START_WRITE) || (req_tuser == CMD_START_READ));

   assign csr_ready  = 1'b1;
   assign timeout_in = (csr_valid && csr_ready) ? csr_data : timeout_ff;

   mbr_tx u_tx (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .start_write (req_tuser == CMD_START_WRITE),
      .dev_id      (req_tdata[7:0]),
      .first_reg   (req_tdata[23:8]),
      .write_value (req_tdata[87:24]),
      .out_ready   (out_ready),
      .busy        (tx_busy),
      .tx_out      (tx_out)
   );

   mbr_rx #(
      .RX_MAX_BYTES (RX_MAX_BYTES)
   ) u_rx (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .cmd           (req_tuser),
      .dev_id        (req_tdata[7:0]),
      .first_reg     (req_tdata[23:8]),
      .rx_byte       (req_tdata[95:88]),
      .timeout_ticks (timeout_ff),
      .cpl           (cpl)
   );

   // Emitted bytes and completions never fall in the same cycle: items are
   // only taken while the emitter is quiet.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      length_in    = length_ff;
      if (out_ready) begin
         rsp_valid_in = tx_out.valid || cpl.valid;
         if (tx_out.valid) begin
            kind_in   = KIND_TX_BYTE;
            byte_in   = tx_out.data;
            last_in   = tx_out.last;
            status_in = STATUS_OK;
            value_in  = 64'd0;
            length_in = '0;
         end else begin
            kind_in   = KIND_COMPLETE;
            byte_in   = 8'h00;
            last_in   = 1'b0;
            status_in = cpl.status;
            value_in  = cpl.value;
            length_in = cpl.length;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         timeout_ff   <= timeout_in;
      end
      kind_ff   <= kind_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      length_ff <= length_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {7'd0, length_ff, value_ff, status_ff, byte_ff};

endmodule
`default_nettype wire

>>> verif/mbr_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the Modbus RTU master: a CRC-16 helper package and a checker module that
// watches the request, result and timeout channels. Depends on rtl/mbr_pkg.sv.

package mbr_check_pkg;
   import mbr_pkg::*;

   // Fold one octet into a CRC-16/MODBUS accumulator, one bit at a time, LSB first
   function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] octet);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int k = 0; k < 8; k++) begin
         fb = r[0] ^ octet[k];
         r  = r >> 1;
         if (fb) r = r ^ CRC_POLY;
      end
      return r;
   endfunction
endpackage

module mbr_checker import mbr_pkg::*, mbr_check_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [95:0] req_tdata,  // dev_id, first_reg, write_value, rx_byte
   input  wire logic [2:0]  req_tuser,  // cmd
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [87:0] rsp_tdata,  // tx_byte, status, read_value, response_length, pad
   input  wire logic        rsp_tuser,  // kind
   input  wire logic        rsp_tlast,  // last
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [15:0] csr_data,
   output int               mismatch_count,
   output int               rsp_outstanding
);

   typedef enum logic [1:0] {LINK_IDLE, LINK_WAIT_WRITE, LINK_WAIT_READ} link_state_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [1:0]  status;
      logic [63:0] value;
      logic [6:0]  length;
   } rsp_item_type;

   link_state_type link_state;
   logic [7:0]     slave_q;
   logic [15:0]    reg_q;
   logic [15:0]    ticks_q;
   logic [15:0]    timeout_q;
   logic [15:0]    rx_crc;
   logic [6:0]     rx_len;
   logic [7:0]     rx_buf [BUF_DEPTH];
   rsp_item_type   rsp_due [$];
   int             mismatches;

   initial begin
      mismatches = 0;
   end

   function automatic rsp_item_type tx_item(input logic [7:0] octet, input logic is_last);
      rsp_item_type it;
      it         = '0;
      it.kind    = KIND_TX_BYTE;
      it.tx_byte = octet;
      it.last    = is_last;
      return it;
   endfunction

   task automatic close_txn(input logic [1:0] status, input logic [63:0] value);
      rsp_item_type it;
      it        = '0;
      it.kind   = KIND_COMPLETE;
      it.status = status;
      it.value  = value;
      it.length = rx_len;
      rsp_due.push_back(it);
      link_state = LINK_IDLE;
   endtask

   // Build the whole request frame, queue its bytes and arm the receive side
   task automatic emit_request(input logic is_write, input logic [7:0] slave,
                               input logic [15:0] regn, input logic [63:0] value);
      logic [7:0]  frm [17];
      logic [15:0] c;
      int          n;
      frm[0] = slave;
      frm[1] = is_write ? FUNC_WRITE : FUNC_READ;
      frm[2] = regn[15:8];
      frm[3] = regn[7:0];
      frm[4] = 8'h00;
      frm[5] = REG_COUNT;
      n      = TX_LEN_READ - 2;
      if (is_write) begin
         frm[6] = BYTE_COUNT;
         for (int w = 0; w < 4; w++) begin
            frm[7 + 2 * w] = value[16 * w + 8 +: 8];
            frm[8 + 2 * w] = value[16 * w +: 8];
         end
         n = TX_LEN_WRITE - 2;
      end
      c = CRC_INIT;
      for (int i = 0; i < n; i++) c = crc16_fold(c, frm[i]);
      frm[n]     = c[7:0];
      frm[n + 1] = c[15:8];
      n          = n + 2;
      for (int i = 0; i < n; i++) rsp_due.push_back(tx_item(frm[i], i == n - 1));
      link_state = is_write ? LINK_WAIT_WRITE : LINK_WAIT_READ;
      slave_q    = slave;
      reg_q      = regn;
      ticks_q    = '0;
      rx_len     = '0;
      rx_crc     = CRC_INIT;
   endtask

   task automatic judge_response();
      logic        is_write;
      logic [15:0] reg_echo;
      logic [15:0] cnt_echo;
      is_write = (link_state == LINK_WAIT_WRITE);
      reg_echo = {rx_buf[2], rx_buf[3]};
      cnt_echo = {rx_buf[4], rx_buf[5]};
      if (rx_len != (is_write ? RSP_LEN_WRITE : RSP_LEN_READ) || rx_crc != 16'h0000)
         close_txn(STATUS_LEN_CRC, '0);
      else if (rx_buf[0] != slave_q)
         close_txn(STATUS_MISMATCH, '0);
      else if (is_write) begin
         if (rx_buf[1] != FUNC_WRITE || reg_echo != reg_q || cnt_echo != {8'h00, REG_COUNT})
            close_txn(STATUS_MISMATCH, '0);
         else
            close_txn(STATUS_OK, '0);
      end else begin
         if (rx_buf[1] != FUNC_READ || rx_buf[2] != BYTE_COUNT)
            close_txn(STATUS_MISMATCH, '0);
         else
            close_txn(STATUS_OK, {rx_buf[9], rx_buf[10], rx_buf[7], rx_buf[8],
                                  rx_buf[5], rx_buf[6], rx_buf[3], rx_buf[4]});
      end
   endtask

   task automatic advance_master(input logic [2:0] cmd, input logic [95:0] data);
      case (cmd)
         CMD_START_WRITE, CMD_START_READ: begin
            emit_request(cmd == CMD_START_WRITE, data[7:0], data[23:8], data[87:24]);
         end
         CMD_RX_BYTE: begin
            if (link_state != LINK_IDLE && rx_len < RX_MAX_BYTES_DEF) begin
               if (rx_len < BUF_DEPTH) rx_buf[rx_len] = data[95:88];
               rx_crc = crc16_fold(rx_crc, data[95:88]);
               rx_len = rx_len + 7'd1;
            end
         end
         CMD_FRAME_END: begin
            if (link_state != LINK_IDLE) judge_response();
         end
         CMD_TICK: begin
            if (link_state != LINK_IDLE) begin
               if (ticks_q < TICK_MAX) ticks_q = ticks_q + 16'd1;
               if (ticks_q >= timeout_q) close_txn(STATUS_TIMEOUT, '0);
            end
         end
         default: ;
      endcase
   endtask

   function automatic string show(input rsp_item_type it);
      return $sformatf("kind %0d byte %02h last %0d status %0d value %016h length %0d",
                       it.kind, it.tx_byte, it.last, it.status, it.value, it.length);
   endfunction

   task automatic note_fault(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mbr_checker: %s", msg);
   endtask

   task automatic check_result();
      rsp_item_type seen;
      rsp_item_type want;
      seen.kind    = rsp_tuser;
      seen.tx_byte = rsp_tdata[7:0];
      seen.last    = rsp_tlast;
      seen.status  = rsp_tdata[9:8];
      seen.value   = rsp_tdata[73:10];
      seen.length  = rsp_tdata[80:74];
      if (rsp_due.size() == 0)
         note_fault({"unexpected result: ", show(seen)});
      else begin
         want = rsp_due.pop_front();
         if (seen !== want) note_fault({"expected ", show(want), "; got ", show(seen)});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         link_state = LINK_IDLE;
         slave_q    = '0;
         reg_q      = '0;
         ticks_q    = '0;
         timeout_q  = TIMEOUT_RESET;
         rx_len     = '0;
         rx_crc     = CRC_INIT;
         rsp_due.delete();
      end else begin
         if (csr_valid && csr_ready) timeout_q = csr_data;
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) advance_master(req_tuser, req_tdata);
      end
      mismatch_count  <= mismatches;
      rsp_outstanding <= rsp_due.size();
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Top-level testbench for modbus_rtu_master_u64_transaction: clock, reset, stimulus and verdict.
// Depends on rtl/mbr_pkg.sv, the block itself and verif/mbr_checker.sv.

// Stimulus runs in two parts. A directed opening pokes items at the idle block, the spare
// command codes, a write and a read start with extreme fields (the read start drops the
// pending write), a good read reply with an all-ones value and a timeout on the very first
// tick. The random part then walks through several timeout settings, from 1 up to 65535,
// and sends mostly whole transactions: a start, then a reply that is good, carries a wrong
// field, a broken CRC, a wrong length, an overflowing byte stream, nothing at all, or at most
// three stray bytes and ticks until the timeout fires. Stray ticks, restarts and noise items are mixed in.
// The sender works in bursts, the receiver stalls on its own pattern and once holds off
// long enough for the block to back up into its input.
module tb;
   import mbr_pkg::*;
   import mbr_check_pkg::*;

   localparam logic [2:0]  CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0]  CMD_UNUSED_LAST  = 3'd7;
   localparam int unsigned CYCLE_LIMIT      = 400000;
   localparam int unsigned ITEMS_PER_PHASE  = 52;
   localparam int unsigned HOLD_OFF_AFTER   = 500;
   localparam int unsigned HOLD_OFF_CYCLES  = 400;
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned DRAIN_CYCLES     = 20;
   localparam int unsigned SILENT_MAX_TICKS = 64;

   // Shapes of the reply that follows a start
   typedef enum int {
      SHAPE_GOOD, SHAPE_MISMATCH, SHAPE_BAD_CRC, SHAPE_BAD_LEN,
      SHAPE_OVERFLOW, SHAPE_EMPTY, SHAPE_SILENT
   } shape_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data   = '0;

   int          mismatch_count;
   int          rsp_outstanding;
   int unsigned cycle_count = 0;
   int unsigned burst_left  = 0;
   int unsigned items_sent  = 0;
   logic [15:0] timeout_now = TIMEOUT_RESET;

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   modbus_rtu_master_u64_transaction uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   mbr_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .rsp_outstanding (rsp_outstanding)
   );

   // Offer one item and hold it until it is taken. Called and left at a falling edge.
   // Between bursts, drop valid for a random gap; a zero gap keeps valid high throughout.
   task automatic offer(input logic [2:0] cmd, input logic [7:0] slave,
                        input logic [15:0] regn, input logic [63:0] value,
                        input logic [7:0] octet);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {octet, value, regn, slave};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      burst_left--;
      if (cmd <= CMD_TICK) items_sent++;
   endtask

   // Items that only use the command and the received byte: fill the rest with junk
   task automatic offer_plain(input logic [2:0] cmd, input logic [7:0] octet);
      offer(cmd, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
            {$urandom, $urandom}, octet);
   endtask

   task automatic start_txn(input logic is_write, output logic [7:0] slave,
                            output logic [15:0] regn);
      slave = 8'($urandom_range(0, 255));
      regn  = 16'($urandom_range(0, 65535));
      offer(is_write ? CMD_START_WRITE : CMD_START_READ, slave, regn,
            {$urandom, $urandom}, 8'($urandom_range(0, 255)));
   endtask

   // Play the slave's side of a transaction: build a reply of the given shape and feed it
   // in byte by byte, with the odd tick in between, then close it with a frame end
   task automatic send_response(input logic is_write, input logic [7:0] slave,
                                input logic [15:0] regn, input shape_type shape,
                                input logic [63:0] data);
      logic [7:0]  frm [$];
      logic [15:0] c;
      int          pick;
      if (shape == SHAPE_SILENT) begin
         repeat ($urandom_range(0, 3)) offer_plain(CMD_RX_BYTE, 8'($urandom_range(0, 255)));
         repeat (timeout_now) offer_plain(CMD_TICK, 8'($urandom_range(0, 255)));
         return;
      end
      frm.push_back(slave);
      if (is_write) begin
         frm.push_back(FUNC_WRITE);
         frm.push_back(regn[15:8]);
         frm.push_back(regn[7:0]);
         frm.push_back(8'h00);
         frm.push_back(REG_COUNT);
      end else begin
         frm.push_back(FUNC_READ);
         frm.push_back(BYTE_COUNT);
         for (int w = 0; w < 4; w++) begin
            frm.push_back(data[16 * w + 8 +: 8]);
            frm.push_back(data[16 * w +: 8]);
         end
      end
      // spoil one header field, keeping the CRC valid
      if (shape == SHAPE_MISMATCH) begin
         pick      = $urandom_range(0, is_write ? 5 : 2);
         frm[pick] = frm[pick] ^ 8'($urandom_range(1, 255));
      end
      // one byte short or one too many, still with a valid CRC
      if (shape == SHAPE_BAD_LEN) begin
         if ($urandom_range(0, 1) == 0) void'(frm.pop_back());
         else frm.push_back(8'($urandom_range(0, 255)));
      end
      c = CRC_INIT;
      foreach (frm[k]) c = crc16_fold(c, frm[k]);
      frm.push_back(c[7:0]);
      frm.push_back(c[15:8]);
      // a single flipped bit anywhere is always caught by the CRC
      if (shape == SHAPE_BAD_CRC) begin
         pick      = $urandom_range(0, frm.size() - 1);
         frm[pick] = frm[pick] ^ (8'h01 << $urandom_range(0, 7));
      end
      if (shape == SHAPE_OVERFLOW) begin
         frm.delete();
         repeat ($urandom_range(RX_MAX_BYTES_DEF, RX_MAX_BYTES_DEF + 8))
            frm.push_back(8'($urandom_range(0, 255)));
      end
      if (shape == SHAPE_EMPTY) frm.delete();
      foreach (frm[k]) begin
         if ($urandom_range(0, 19) == 0) offer_plain(CMD_TICK, 8'($urandom_range(0, 255)));
         offer_plain(CMD_RX_BYTE, frm[k]);
      end
      offer_plain(CMD_FRAME_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic random_sequence();
      int          r;
      int          m;
      logic        is_write;
      logic [7:0]  slave;
      logic [15:0] regn;
      shape_type   shape;
      r        = $urandom_range(0, 99);
      is_write = 1'($urandom_range(0, 1));
      if (r < 72) begin
         start_txn(is_write, slave, regn);
         m = $urandom_range(0, 99);
         if      (m < 40) shape = SHAPE_GOOD;
         else if (m < 60) shape = SHAPE_MISMATCH;
         else if (m < 70) shape = SHAPE_BAD_CRC;
         else if (m < 80) shape = SHAPE_BAD_LEN;
         else if (m < 86) shape = SHAPE_OVERFLOW;
         else if (m < 90) shape = SHAPE_EMPTY;
         else shape = (timeout_now <= SILENT_MAX_TICKS) ? SHAPE_SILENT : SHAPE_GOOD;
         send_response(is_write, slave, regn, shape, {$urandom, $urandom});
      end else if (r < 80) begin
         // start, then a few bytes; the next sequence's start drops this transaction
         start_txn(is_write, slave, regn);
         repeat ($urandom_range(0, 4)) offer_plain(CMD_RX_BYTE, 8'($urandom_range(0, 255)));
      end else if (r < 92) begin
         repeat ($urandom_range(1, 3))
            offer_plain(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 4)) offer_plain(CMD_TICK, 8'($urandom_range(0, 255)));
      end
   endtask

   // Write the timeout register once nothing is in flight. Let the block settle first:
   // a trailing item with no result may still be in its pipeline.
   task automatic load_timeout(input logic [15:0] ticks);
      req_tvalid <= 1'b0;
      wait (rsp_outstanding == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_data  <= ticks;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid   <= 1'b0;
      timeout_now = ticks;
      burst_left  = 0;
   endtask

   // Receiver: stall on a pattern of its own, and once hold off for a long stretch
   initial begin
      int unsigned span;
      int unsigned mode;
      bit          held_off;
      held_off = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (!held_off && cycle_count > HOLD_OFF_AFTER) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(5, 60);
         repeat (span) begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // Watchdog: end a run that hangs
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      logic [15:0] phase_ticks [6];
      int unsigned goal;
      phase_ticks = '{16'hFFFF, 16'd4, TIMEOUT_RESET, 16'($urandom_range(6, 60)), 16'd1,
                      16'($urandom_range(61, 65534))};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Idle block: bytes, frame ends and ticks are dropped, as are the spare codes
      offer_plain(CMD_RX_BYTE, 8'hA5);
      offer_plain(CMD_FRAME_END, 8'h00);
      offer_plain(CMD_TICK, 8'hFF);
      for (int u = CMD_UNUSED_FIRST; u <= CMD_UNUSED_LAST; u++) offer_plain(3'(u), 8'h5A);
      // Extreme starts; the read start abandons the write still waiting
      offer(CMD_START_WRITE, 8'hFF, 16'hFFFF, '1, 8'hFF);
      offer(CMD_START_READ, 8'h00, 16'h0000, '0, 8'h00);
      send_response(1'b0, 8'h00, 16'h0000, SHAPE_GOOD, '1);
      // Shortest timeout: the first tick ends the transaction
      load_timeout(16'd1);
      offer(CMD_START_WRITE, 8'h00, 16'h0000, '0, 8'h00);
      offer_plain(CMD_TICK, 8'h00);

      // Random transactions under each timeout setting; a frame end closes every phase
      foreach (phase_ticks[p]) begin
         load_timeout(phase_ticks[p]);
         goal = items_sent + ITEMS_PER_PHASE;
         while (items_sent < goal) random_sequence();
         offer_plain(CMD_FRAME_END, 8'($urandom_range(0, 255)));
      end

      req_tvalid <= 1'b0;
      wait (rsp_outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && rsp_outstanding == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
